### hdl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// types and constants shared by the first-fit region allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned NEED_W      = DATA_W + 1;
  localparam int unsigned ALIGN_BYTES = 4;
  localparam logic [DATA_W-1:0] POOL_RESET = 16'd10000;

  localparam int unsigned STATUS_W = 3;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_ALLOCATED  = 3'd0;
  localparam status_t STAT_NO_SPACE   = 3'd1;
  localparam status_t STAT_TABLE_FULL = 3'd2;
  localparam status_t STAT_FREED      = 3'd3;
  localparam status_t STAT_NOT_FOUND  = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_DEL,
    S_FIN
  } state_t;

endpackage

### hdl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// first-fit allocator over a sorted region table held in a small memory
// ----------------------------------------------------------------------------
// sequence: a transaction scans the table, shifts entries to insert or delete when
//   it finds a gap or a matching key, then loads the result; an allocate on a full
//   table goes straight to the result; the next transaction is accepted in the cycle after the result is loaded
// throughput: one transaction at a time, set by the single memory read port and
//   the one shared subtract/compare unit walking the table one entry per cycle
// reset: region count cleared, pool size set to 10000, table contents untouched
// ----------------------------------------------------------------------------
module first_fit_region_allocator
  import ffra_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // size_bytes[15:0], free_key[31:16]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], offset[18:3], zero pad
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned MEM_W = 2 * DATA_W;

  state_t state_r, state_nxt;

  logic [MEM_W-1:0]  region_mem [MAX_REGIONS];
  logic [MEM_W-1:0]  rdata_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  logic [DATA_W-1:0] pool_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [NEED_W-1:0] cur_r, cur_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic              kind_r, kind_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_offset_r, out_offset_nxt;

  logic              in_fire;
  logic              out_free;
  logic              at_end;
  logic              table_full;
  logic [DATA_W-1:0] rd_start;
  logic [DATA_W-1:0] rd_len;
  logic [NEED_W-1:0] round_sum;
  logic [NEED_W-1:0] round_need;
  logic [NEED_W-1:0] cmp_lhs;
  logic [NEED_W:0]   cmp_diff;
  logic              fits;
  logic [CNT_W-1:0]  ptr_next_cnt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign at_end     = (idx_r == count_r);
  assign table_full = (count_r == CNT_W'(MAX_REGIONS));
  assign rd_start   = rdata_r[MEM_W-1:DATA_W];
  assign rd_len     = rdata_r[DATA_W-1:0];

  assign round_sum  = {1'b0, in_tdata[15:0]} + NEED_W'(ALIGN_BYTES - 1);
  assign round_need = round_sum & ~NEED_W'(ALIGN_BYTES - 1);

  // shared subtract/compare: gap ahead of the current entry or the pool tail
  assign cmp_lhs  = at_end ? {1'b0, pool_r} : {1'b0, rd_start};
  assign cmp_diff = {1'b0, cmp_lhs} - {1'b0, cur_r};
  assign fits     = !cmp_diff[NEED_W] && (cmp_diff[NEED_W-1:0] >= need_r);

  assign ptr_next_cnt = CNT_W'(ptr_r) + CNT_W'(1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_offset_r, out_status_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == KIND_ALLOC && table_full) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (kind_r == KIND_ALLOC) begin
          if (fits) begin
            state_nxt = S_INS;
          end else if (at_end) begin
            state_nxt = S_FIN;
          end
        end else begin
          if (at_end) begin
            state_nxt = S_FIN;
          end else if (rd_start == key_r) begin
            state_nxt = S_DEL;
          end
        end
      end
      S_INS: begin
        if (ptr_r == pos_r) begin
          state_nxt = S_FIN;
        end
      end
      S_DEL: begin
        if (ptr_next_cnt >= count_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    cur_nxt        = cur_r;
    need_nxt       = need_r;
    key_nxt        = key_r;
    kind_nxt       = kind_r;
    status_nxt     = status_r;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = rdata_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_tuser;
          need_nxt   = round_need;
          key_nxt    = in_tdata[31:16];
          idx_nxt    = '0;
          cur_nxt    = '0;
          status_nxt = STAT_TABLE_FULL;
        end
      end
      S_SCAN: begin
        rd_addr = IDX_W'(idx_r + CNT_W'(1));
        if (kind_r == KIND_ALLOC) begin
          if (fits) begin
            pos_nxt = idx_r[IDX_W-1:0];
            ptr_nxt = count_r[IDX_W-1:0];
            rd_addr = IDX_W'(count_r - CNT_W'(1));
          end else if (at_end) begin
            status_nxt = STAT_NO_SPACE;
          end else begin
            cur_nxt = {1'b0, rd_start} + {1'b0, rd_len};
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else begin
          if (at_end) begin
            status_nxt = STAT_NOT_FOUND;
          end else if (rd_start == key_r) begin
            pos_nxt = idx_r[IDX_W-1:0];
            ptr_nxt = idx_r[IDX_W-1:0];
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        if (ptr_r == pos_r) begin
          mem_waddr  = pos_r;
          mem_wdata  = {cur_r[DATA_W-1:0], need_r[DATA_W-1:0]};
          count_nxt  = count_r + CNT_W'(1);
          status_nxt = STAT_ALLOCATED;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
          rd_addr = ptr_r - IDX_W'(2);
        end
      end
      S_DEL: begin
        if (ptr_next_cnt < count_r) begin
          mem_we  = 1'b1;
          ptr_nxt = ptr_r + IDX_W'(1);
          rd_addr = ptr_r + IDX_W'(2);
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = STAT_FREED;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_offset_nxt = (status_r == STAT_ALLOCATED) ? cur_r[DATA_W-1:0] : '0;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      region_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= region_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pool_r      <= POOL_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pool_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    cur_r        <= cur_nxt;
    need_r       <= need_nxt;
    key_r        <= key_nxt;
    kind_r       <= kind_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= count_r)
    else $error("scan index past live entries");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_ALLOCATED |-> out_offset_r == '0)
    else $error("nonzero offset on failed or free transaction");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after accepting a transaction");

endmodule

### tb/first_fit_region_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_tb
// self-checking stream testbench for the first-fit region allocator: a short
// table of directed requests, then random allocate/free traffic across several
// pool sizes and sender/receiver idling patterns, every result checked in
// order against the expected value of its row or a software copy of the region table
// ----------------------------------------------------------------------------
module first_fit_region_allocator_tb;
  import ffra_pkg::*;

  localparam int unsigned REGION_SLOTS = 16;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_REQUESTS = 90;
  localparam int unsigned SETTLE_CYCLES = 2 * REGION_SLOTS + 8;
  localparam int unsigned MAX_REPORTS = 50;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] offset;
  } grant_t;

  typedef struct {
    logic              kind;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] key;
    bit                typed;
    grant_t            grant;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // size_bytes[15:0], free_key[31:16]
  logic        in_tuser = 1'b0;  // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // status[2:0], offset[18:3], zero pad
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // software copy of the allocator state
  int unsigned region_base [REGION_SLOTS];
  int unsigned region_size [REGION_SLOTS];
  int unsigned live_count = 0;
  int unsigned pool_size = POOL_RESET;

  grant_t       pending_grants[$];
  request_row_t directed_rows[$];
  grant_t       seen_grant;
  grant_t       want_grant;
  idle_mode_t   idle_mode = IDLE_NONE;
  int unsigned  error_count = 0;

  always #5 clk = ~clk;

  first_fit_region_allocator #(
    .MAX_REGIONS(REGION_SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic bit hold_off(input bit receiver_side);
    int unsigned pct;
    pct = 0;
    case (idle_mode)
      IDLE_SENDER: begin
        if (!receiver_side) pct = 58;
      end
      IDLE_RECEIVER: begin
        if (receiver_side) pct = 58;
      end
      IDLE_BOTH: begin
        pct = 19;
      end
      default: begin
        pct = 0;
      end
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // first-fit search, insert and remove on the software region table
  function automatic grant_t allocate_or_free(input logic kind, input logic [DATA_W-1:0] size,
                                              input logic [DATA_W-1:0] key);
    grant_t      g;
    int unsigned need;
    int unsigned cur;
    int unsigned pos;
    bit          found;
    g.status = STAT_NOT_FOUND;
    g.offset = '0;
    found = 1'b0;
    pos = 0;
    cur = 0;
    if (kind == KIND_ALLOC) begin
      if (live_count >= REGION_SLOTS) begin
        g.status = STAT_TABLE_FULL;
      end else begin
        need = ((int'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        for (int i = 0; i < live_count; i++) begin
          if (!found) begin
            if (region_base[i] >= cur && region_base[i] - cur >= need) begin
              found = 1'b1;
              pos = i;
            end else begin
              cur = region_base[i] + region_size[i];
            end
          end
        end
        if (!found && pool_size >= cur && pool_size - cur >= need) begin
          found = 1'b1;
          pos = live_count;
        end
        if (found) begin
          for (int i = live_count; i > pos; i--) begin
            region_base[i] = region_base[i-1];
            region_size[i] = region_size[i-1];
          end
          region_base[pos] = cur & 16'hFFFF;
          region_size[pos] = need & 16'hFFFF;
          live_count++;
          g.status = STAT_ALLOCATED;
          g.offset = cur[DATA_W-1:0];
        end else begin
          g.status = STAT_NO_SPACE;
        end
      end
    end else begin
      for (int i = 0; i < live_count; i++) begin
        if (!found && region_base[i] == key) begin
          found = 1'b1;
          pos = i;
        end
      end
      if (found) begin
        for (int i = pos; i + 1 < live_count; i++) begin
          region_base[i] = region_base[i+1];
          region_size[i] = region_size[i+1];
        end
        live_count--;
        g.status = STAT_FREED;
      end
    end
    return g;
  endfunction

  task automatic send_request(input logic kind, input logic [DATA_W-1:0] size,
                              input logic [DATA_W-1:0] key, output grant_t predicted);
    while (hold_off(1'b0)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {key, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = allocate_or_free(kind, size, key);
  endtask

  task automatic drain_grants();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic set_pool_size(input logic [15:0] value);
    drain_grants();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_size = value;
  endtask

  task automatic add_row(input logic kind, input logic [DATA_W-1:0] size,
                         input logic [DATA_W-1:0] key, input bit typed,
                         input status_t status, input logic [DATA_W-1:0] offset);
    request_row_t r;
    r.kind = kind;
    r.size = size;
    r.key = key;
    r.typed = typed;
    r.grant.status = status;
    r.grant.offset = offset;
    directed_rows.push_back(r);
  endtask

  // result side: check each transaction and stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_grant.status = out_tdata[2:0];
      seen_grant.offset = out_tdata[18:3];
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d offset %0d",
                                  seen_grant.status, seen_grant.offset));
      end else begin
        want_grant = pending_grants.pop_front();
        if (seen_grant.status !== want_grant.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    seen_grant.status, want_grant.status));
        if (seen_grant.offset !== want_grant.offset)
          report_mismatch($sformatf("offset %0d, expected %0d",
                                    seen_grant.offset, want_grant.offset));
      end
    end
    out_tready <= rst_n && !hold_off(1'b1);
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    grant_t           g;
    logic             kind;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] key;
    int unsigned      pick;
    logic [15:0]      pools [RANDOM_PHASES];

    add_row(KIND_FREE,  16'd0,     16'd0,     1, STAT_NOT_FOUND, 16'd0);
    add_row(KIND_ALLOC, 16'd0,     16'hFFFF,  1, STAT_ALLOCATED, 16'd0);
    add_row(KIND_ALLOC, 16'd1,     16'd0,     0, STAT_ALLOCATED, 16'd0);
    add_row(KIND_ALLOC, 16'hFFFF,  16'd0,     1, STAT_NO_SPACE,  16'd0);
    add_row(KIND_ALLOC, 16'd65533, 16'd0,     1, STAT_NO_SPACE,  16'd0);
    add_row(KIND_FREE,  16'hFFFF,  16'd0,     1, STAT_FREED,     16'd0);
    add_row(KIND_FREE,  16'd0,     16'd0,     1, STAT_FREED,     16'd0);
    add_row(KIND_FREE,  16'd0,     16'hFFFF,  1, STAT_NOT_FOUND, 16'd0);
    for (int i = 0; i < REGION_SLOTS; i++)
      add_row(KIND_ALLOC, 16'd4, 16'hA5A5, 0, STAT_ALLOCATED, 16'd0);
    add_row(KIND_ALLOC, 16'd0,     16'd0,     1, STAT_TABLE_FULL, 16'd0);
    add_row(KIND_FREE,  16'd0,     16'd4,     1, STAT_FREED,      16'd0);
    add_row(KIND_ALLOC, 16'd3,     16'd0,     1, STAT_ALLOCATED,  16'd4);

    pools[0] = 16'hFFFF;
    pools[1] = 16'd0;
    pools[2] = 16'd4000;
    pools[3] = POOL_RESET;
    pools[4] = 16'hFFFF;
    pools[5] = 16'd100;
    pools[6] = 16'($urandom_range(65535));
    pools[7] = 16'd1200;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].size, directed_rows[i].key, g);
      if (directed_rows[i].typed) pending_grants.push_back(directed_rows[i].grant);
      else pending_grants.push_back(g);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_pool_size(pools[p]);
      idle_mode = idle_mode_t'(p % 4);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(49) == 0) drain_grants();
        pick = $urandom_range(99);
        key = 16'($urandom_range(65535));
        size = 16'($urandom_range(65535));
        if (pick < 45) begin
          kind = KIND_ALLOC;
          size = 16'($urandom_range(pool_size / 6 + 8));
        end else if (pick < 48) begin
          kind = KIND_ALLOC;
          size = '0;
        end else if (pick < 53) begin
          kind = KIND_ALLOC;
        end else if (pick < 90 && live_count != 0) begin
          kind = KIND_FREE;
          key = region_base[$urandom_range(live_count - 1)][DATA_W-1:0];
        end else begin
          kind = KIND_FREE;
        end
        send_request(kind, size, key, g);
        pending_grants.push_back(g);
      end
    end

    drain_grants();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ffra_pkg.sv
hdl/first_fit_region_allocator.sv
tb/first_fit_region_allocator_tb.sv
